@@ sv/dwpid_pkg.sv @@
// Shared types and constants for the dual-wheel speed controller.
// Action and register codes, reset values and the structs between the top level and a wheel.
// No dependencies.
package dwpid_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		ACT_SET_TARGET = 2'd0,
		ACT_ESTOP      = 2'd1,
		ACT_MS_TICK    = 2'd2,
		ACT_CONTROL    = 2'd3
	} action_t;

	// Register word indexes, byte address 4*index
	typedef enum logic [2:0] {
		REG_TIMEOUT     = 3'd0,
		REG_TGT_LIMIT   = 3'd1,
		REG_DRIVE_LIMIT = 3'd2,
		REG_FEED_FWD    = 3'd3,
		REG_PROP_GAIN   = 3'd4,
		REG_DERIV_GAIN  = 3'd5,
		REG_INTEG_LIMIT = 3'd6
	} reg_idx_t;

	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int CMD_W    = 16;
	localparam int TGT_W    = 11;
	localparam int INTEG_W  = 16;
	localparam int DRIVE_W  = 17;
	localparam int OUT_W    = 56;

	localparam logic [15:0] TIMEOUT_RST     = 16'd200;
	localparam logic [9:0]  TGT_LIMIT_RST   = 10'd150;
	localparam logic [15:0] DRIVE_LIMIT_RST = 16'd7199;
	localparam logic [15:0] FEED_FWD_RST    = 16'd3600;
	localparam logic [7:0]  PROP_GAIN_RST   = 8'd18;
	localparam logic [7:0]  DERIV_GAIN_RST  = 8'd4;
	localparam logic [14:0] INTEG_LIMIT_RST = 15'd8000;
	localparam logic [15:0] AGE_RST         = 16'd201;
	localparam logic [15:0] AGE_MAX         = 16'hFFFF;

	// Loop settings seen by each wheel
	typedef struct packed {
		logic [15:0] drive_limit;
		logic [15:0] feed_forward;
		logic [7:0]  prop_gain;
		logic [7:0]  deriv_gain;
		logic [14:0] integral_limit;
	} gains_t;

	// Per-item control toward a wheel
	typedef struct packed {
		logic adv;  // item leaves the input stage this cycle
		logic pid;  // run one loop step
		logic clr;  // zero the integral (estop or timeout stop)
	} wheel_ctl_t;

endpackage

@@ sv/dwpid_wheel.sv @@
// One wheel of the speed loop: error, clamped integral, gain products, drive clamp.
// Holds the wheel's integral and last error; stage 2 sums and limits the drive.
// Depends on dwpid_pkg.
module dwpid_wheel #(
	parameter int SPEED_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dwpid_pkg::wheel_ctl_t                  ctl,
	input  dwpid_pkg::gains_t                      gains,
	input  logic signed [dwpid_pkg::TGT_W-1:0]     target,
	input  logic signed [SPEED_BITS-1:0]           speed,
	output logic signed [dwpid_pkg::DRIVE_W-1:0]   drive
);
	import dwpid_pkg::*;

	localparam int EW = ((SPEED_BITS > TGT_W) ? SPEED_BITS : TGT_W) + 1;
	localparam int IW = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
	localparam int PW = EW + 9;
	localparam int DW = EW + 10;
	localparam int SW = EW + 12;

	logic signed [INTEG_W-1:0] integ_q;
	logic signed [EW-1:0]      last_q;

	logic signed [EW-1:0]      err;
	logic signed [EW:0]        derr;
	logic signed [IW-1:0]      isum;
	logic signed [IW-1:0]      ilim;
	logic signed [IW-1:0]      iclamp;
	logic signed [INTEG_W-1:0] integ_nxt;
	logic signed [PW-1:0]      prod_p;
	logic signed [DW-1:0]      prod_d;
	logic signed [DRIVE_W-1:0] ff;
	logic                      zero;

	logic                      run_s2;
	logic signed [DRIVE_W-1:0] ff_s2;
	logic signed [PW-1:0]      p_s2;
	logic signed [DW-1:0]      d_s2;
	logic signed [INTEG_W-1:0] integ_s2;

	logic signed [INTEG_W:0]   rnd;
	logic signed [INTEG_W:0]   idiv;
	logic signed [SW-1:0]      sum;
	logic signed [SW-1:0]      plim;
	logic signed [SW-1:0]      dclamp;

	// Stage 1: error, integral update and gain products
	assign zero   = (target == '0);
	assign err    = {{(EW-TGT_W){target[TGT_W-1]}}, target}
		- {{(EW-SPEED_BITS){speed[SPEED_BITS-1]}}, speed};
	assign derr   = {err[EW-1], err} - {last_q[EW-1], last_q};
	assign isum   = IW'(integ_q) + IW'(err);
	assign ilim   = {{(IW-15){1'b0}}, gains.integral_limit};
	assign prod_p = $signed({1'b0, gains.prop_gain}) * err;
	assign prod_d = $signed({1'b0, gains.deriv_gain}) * derr;
	assign ff     = target[TGT_W-1] ? -$signed({1'b0, gains.feed_forward})
		: $signed({1'b0, gains.feed_forward});

	always_comb begin
		if (isum > ilim) begin
			iclamp = ilim;
		end else if (isum < -ilim) begin
			iclamp = -ilim;
		end else begin
			iclamp = isum;
		end
	end
	assign integ_nxt = iclamp[INTEG_W-1:0];

	// Update loop memory as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			last_q  <= '0;
		end else if (ctl.adv) begin
			if (ctl.pid) begin
				if (zero) begin
					integ_q <= '0;
					last_q  <= '0;
				end else begin
					integ_q <= integ_nxt;
					last_q  <= err;
				end
			end else if (ctl.clr) begin
				integ_q <= '0;
			end
		end
	end

	// Stage 2 operands
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			run_s2   <= ctl.pid && !zero;
			ff_s2    <= ff;
			p_s2     <= prod_p;
			d_s2     <= prod_d;
			integ_s2 <= integ_nxt;
		end
	end

	// Stage 2: integral over 8 toward zero, sum, drive clamp
	assign rnd  = (INTEG_W+1)'(integ_s2) + (integ_s2[INTEG_W-1] ? 17'sd7 : 17'sd0);
	assign idiv = rnd >>> 3;
	assign sum  = SW'(ff_s2) + SW'(p_s2) + SW'(idiv) + SW'(d_s2);
	assign plim = {{(SW-16){1'b0}}, gains.drive_limit};

	always_comb begin
		if (sum > plim) begin
			dclamp = plim;
		end else if (sum < -plim) begin
			dclamp = -plim;
		end else begin
			dclamp = sum;
		end
	end

	assign drive = run_s2 ? dclamp[DRIVE_W-1:0] : '0;

endmodule

@@ sv/dual_wheel_pid_with_command_timeout.sv @@
// Dual-wheel speed controller with command timeout; top level.
// An accepted item passes the input register, the loop stage and the output register before
// its result is valid on the output. Throughput: one item per cycle unless the result side stalls;
// state updates as an item leaves the input register, so the next item sees it at once.
// Reset (asynchronous, active low) clears targets, integrals and last errors, loads the
// register defaults and sets the command age to one past the default timeout.
module dual_wheel_pid_with_command_timeout #(
	parameter int SPEED_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// input stream
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// left_target_cmd, right_target_cmd, left_speed, right_speed
	input  logic [((32+2*SPEED_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// action
	input  logic [1:0]                                s_axis_tuser,
	// result stream
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// left_drive, right_drive, left_target_now, right_target_now
	output logic [dwpid_pkg::OUT_W-1:0]               m_axis_tdata,
	// timed_out
	output logic [0:0]                                m_axis_tuser,
	// register port
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [dwpid_pkg::PADDR_W-1:0]             paddr,
	input  logic [dwpid_pkg::PDATA_W-1:0]             pwdata,
	output logic [dwpid_pkg::PDATA_W-1:0]             prdata,
	output logic                                      pready
);
	import dwpid_pkg::*;

	localparam int SPD_LO = 2 * CMD_W;

	// registers
	logic [15:0] timeout_q;
	logic [9:0]  tgt_limit_q;
	gains_t      gains_q;
	reg_idx_t    widx;

	// input stage
	logic                         v_s1;
	action_t                      act_s1;
	logic signed [CMD_W-1:0]      lcmd_s1, rcmd_s1;
	logic signed [SPEED_BITS-1:0] lspd_s1, rspd_s1;

	// controller state
	logic [15:0]             age_q;
	logic signed [TGT_W-1:0] ltgt_q, rtgt_q;

	// loop stage
	logic                    res_s2;
	logic                    to_s2;
	logic signed [TGT_W-1:0] ltgt_s2, rtgt_s2;

	// output register
	logic                      out_vld_q;
	logic                      to_q;
	logic signed [DRIVE_W-1:0] ldrv_q, rdrv_q;
	logic signed [TGT_W-1:0]   ltgt_o_q, rtgt_o_q;

	logic                      en_out, en_s2, en_s1, adv;
	logic                      is_ctl, stale;
	wheel_ctl_t                wctl;
	logic signed [DRIVE_W-1:0] ldrv, rdrv;

	function automatic logic signed [TGT_W-1:0] clamp_tgt(
		input logic signed [CMD_W-1:0] c,
		input logic [9:0]              lim
	);
		logic signed [CMD_W:0] c17;
		logic signed [CMD_W:0] l17;
		logic signed [CMD_W:0] r;
		c17 = {c[CMD_W-1], c};
		l17 = {{(CMD_W-9){1'b0}}, lim};
		if (c17 > l17) begin
			r = l17;
		end else if (c17 < -l17) begin
			r = -l17;
		end else begin
			r = c17;
		end
		return r[TGT_W-1:0];
	endfunction

	// Register port: write on the access phase, read back any time
	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q              <= TIMEOUT_RST;
			tgt_limit_q            <= TGT_LIMIT_RST;
			gains_q.drive_limit    <= DRIVE_LIMIT_RST;
			gains_q.feed_forward   <= FEED_FWD_RST;
			gains_q.prop_gain      <= PROP_GAIN_RST;
			gains_q.deriv_gain     <= DERIV_GAIN_RST;
			gains_q.integral_limit <= INTEG_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				REG_TIMEOUT:     timeout_q              <= pwdata[15:0];
				REG_TGT_LIMIT:   tgt_limit_q            <= pwdata[9:0];
				REG_DRIVE_LIMIT: gains_q.drive_limit    <= pwdata[15:0];
				REG_FEED_FWD:    gains_q.feed_forward   <= pwdata[15:0];
				REG_PROP_GAIN:   gains_q.prop_gain      <= pwdata[7:0];
				REG_DERIV_GAIN:  gains_q.deriv_gain     <= pwdata[7:0];
				REG_INTEG_LIMIT: gains_q.integral_limit <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_TIMEOUT:     prdata = {16'd0, timeout_q};
			REG_TGT_LIMIT:   prdata = {22'd0, tgt_limit_q};
			REG_DRIVE_LIMIT: prdata = {16'd0, gains_q.drive_limit};
			REG_FEED_FWD:    prdata = {16'd0, gains_q.feed_forward};
			REG_PROP_GAIN:   prdata = {24'd0, gains_q.prop_gain};
			REG_DERIV_GAIN:  prdata = {24'd0, gains_q.deriv_gain};
			REG_INTEG_LIMIT: prdata = {17'd0, gains_q.integral_limit};
			default:         prdata = '0;
		endcase
	end

	// Flow control: a stage moves when the one after it is free or moving
	assign en_out        = !out_vld_q || m_axis_tready;
	assign en_s2         = !res_s2 || en_out;
	assign en_s1         = !v_s1 || en_s2;
	assign adv           = v_s1 && en_s2;
	assign s_axis_tready = en_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			act_s1  <= action_t'(s_axis_tuser);
			lcmd_s1 <= s_axis_tdata[CMD_W-1:0];
			rcmd_s1 <= s_axis_tdata[2*CMD_W-1:CMD_W];
			lspd_s1 <= s_axis_tdata[SPD_LO +: SPEED_BITS];
			rspd_s1 <= s_axis_tdata[SPD_LO+SPEED_BITS +: SPEED_BITS];
		end
	end

	// Decode the item against the command age
	assign is_ctl   = (act_s1 == ACT_CONTROL);
	assign stale    = (age_q > timeout_q);
	assign wctl.adv = adv;
	assign wctl.pid = is_ctl && !stale;
	assign wctl.clr = (act_s1 == ACT_ESTOP) || (is_ctl && stale);

	// Targets and command age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q  <= AGE_RST;
			ltgt_q <= '0;
			rtgt_q <= '0;
		end else if (adv) begin
			unique case (act_s1)
				ACT_SET_TARGET: begin
					ltgt_q <= clamp_tgt(lcmd_s1, tgt_limit_q);
					rtgt_q <= clamp_tgt(rcmd_s1, tgt_limit_q);
					age_q  <= '0;
				end
				ACT_ESTOP: begin
					ltgt_q <= '0;
					rtgt_q <= '0;
					age_q  <= '0;
				end
				ACT_MS_TICK: begin
					if (!stale && age_q != AGE_MAX) begin
						age_q <= age_q + 16'd1;
					end
				end
				ACT_CONTROL: begin
					if (stale) begin
						ltgt_q <= '0;
						rtgt_q <= '0;
					end
				end
			endcase
		end
	end

	// Loop stage: only estop and control items carry a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (en_s2) begin
			res_s2 <= v_s1 && (act_s1 == ACT_ESTOP || act_s1 == ACT_CONTROL);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			to_s2   <= is_ctl && stale;
			ltgt_s2 <= (is_ctl && !stale) ? ltgt_q : '0;
			rtgt_s2 <= (is_ctl && !stale) ? rtgt_q : '0;
		end
	end

	dwpid_wheel #(
		.SPEED_BITS (SPEED_BITS)
	) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.gains  (gains_q),
		.target (ltgt_q),
		.speed  (lspd_s1),
		.drive  (ldrv)
	);

	dwpid_wheel #(
		.SPEED_BITS (SPEED_BITS)
	) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.gains  (gains_q),
		.target (rtgt_q),
		.speed  (rspd_s1),
		.drive  (rdrv)
	);

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en_out) begin
			out_vld_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && res_s2) begin
			ldrv_q   <= ldrv;
			rdrv_q   <= rdrv;
			to_q     <= to_s2;
			ltgt_o_q <= ltgt_s2;
			rtgt_o_q <= rtgt_s2;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {rtgt_o_q, ltgt_o_q, rdrv_q, ldrv_q};
	assign m_axis_tuser  = to_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the dual-wheel speed controller with command timeout.
// Drives item and register traffic, and checks every result against a scoreboard predictor.
// Depends on dwpid_pkg and the dual_wheel_pid_with_command_timeout top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dwpid_pkg::*;

	localparam int SPD_W = 16;
	localparam int IN_W = ((32 + 2*SPD_W + 7)/8)*8;
	localparam int RD_LO = DRIVE_W;
	localparam int LT_LO = 2*DRIVE_W;
	localparam int RT_LO = 2*DRIVE_W + TGT_W;
	localparam logic [2:0] UNMAPPED_REG = 3'd7;
	localparam int MAX_PRINT = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 10;

	// One expected result transfer
	typedef struct {
		logic [DRIVE_W-1:0] left_drive;
		logic [DRIVE_W-1:0] right_drive;
		logic               timed_out;
		logic [TGT_W-1:0]   left_tgt;
		logic [TGT_W-1:0]   right_tgt;
	} drive_result_t;

	// Predictor of the controller plus the queue of drive results still to arrive
	class wheel_scoreboard;
		int cfg_timeout, cfg_tgt_limit, cfg_drive_limit, cfg_feed_fwd;
		int cfg_kp, cfg_kd, cfg_integ_limit;
		longint age, left_tgt, right_tgt;
		longint left_integ, right_integ, left_last, right_last;
		drive_result_t drive_q[$];
		int errors;
		int n_checked;

		function new();
			cfg_timeout = int'(TIMEOUT_RST);
			cfg_tgt_limit = int'(TGT_LIMIT_RST);
			cfg_drive_limit = int'(DRIVE_LIMIT_RST);
			cfg_feed_fwd = int'(FEED_FWD_RST);
			cfg_kp = int'(PROP_GAIN_RST);
			cfg_kd = int'(DERIV_GAIN_RST);
			cfg_integ_limit = int'(INTEG_LIMIT_RST);
			age = longint'(AGE_RST);
			left_tgt = 0;
			right_tgt = 0;
			left_integ = 0;
			right_integ = 0;
			left_last = 0;
			right_last = 0;
			errors = 0;
			n_checked = 0;
		endfunction

		function longint clamp(longint v, longint lim);
			if (v < -lim)
				return -lim;
			if (v > lim)
				return lim;
			return v;
		endfunction

		// Register writes keep only the register's own width; unmapped words are dropped
		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_TIMEOUT:     cfg_timeout = int'(value[15:0]);
				REG_TGT_LIMIT:   cfg_tgt_limit = int'(value[9:0]);
				REG_DRIVE_LIMIT: cfg_drive_limit = int'(value[15:0]);
				REG_FEED_FWD:    cfg_feed_fwd = int'(value[15:0]);
				REG_PROP_GAIN:   cfg_kp = int'(value[7:0]);
				REG_DERIV_GAIN:  cfg_kd = int'(value[7:0]);
				REG_INTEG_LIMIT: cfg_integ_limit = int'(value[14:0]);
				default: ;
			endcase
		endfunction

		// One loop step of a wheel; a zero target parks the wheel and clears its history
		function longint wheel_drive(longint tgt, longint speed, inout longint integ,
				inout longint last_err);
			longint err;
			longint drv;
			if (tgt == 0) begin
				integ = 0;
				last_err = 0;
				return 0;
			end
			err = tgt - speed;
			integ = clamp(integ + err, longint'(cfg_integ_limit));
			drv = (tgt > 0 ? longint'(cfg_feed_fwd) : -longint'(cfg_feed_fwd))
				+ longint'(cfg_kp) * err + integ / 8
				+ longint'(cfg_kd) * (err - last_err);
			last_err = err;
			return clamp(drv, longint'(cfg_drive_limit));
		endfunction

		// Advance the prediction by one accepted input transfer
		function void note_item(action_t act, logic [IN_W-1:0] data);
			longint l_spd, r_spd, ld, rd;
			drive_result_t r;
			l_spd = $signed(data[32 +: SPD_W]);
			r_spd = $signed(data[48 +: SPD_W]);
			ld = 0;
			rd = 0;
			r.timed_out = 1'b0;
			case (act)
				ACT_SET_TARGET: begin
					left_tgt = clamp($signed(data[15:0]), longint'(cfg_tgt_limit));
					right_tgt = clamp($signed(data[31:16]), longint'(cfg_tgt_limit));
					age = 0;
					return;
				end
				ACT_MS_TICK: begin
					if (age <= longint'(cfg_timeout) && age < longint'(AGE_MAX))
						age++;
					return;
				end
				ACT_ESTOP: begin
					left_tgt = 0;
					right_tgt = 0;
					left_integ = 0;
					right_integ = 0;
					age = 0;
				end
				default: begin
					if (age > longint'(cfg_timeout)) begin
						// command went stale: stop both wheels
						left_tgt = 0;
						right_tgt = 0;
						left_integ = 0;
						right_integ = 0;
						r.timed_out = 1'b1;
					end else begin
						ld = wheel_drive(left_tgt, l_spd, left_integ, left_last);
						rd = wheel_drive(right_tgt, r_spd, right_integ, right_last);
					end
				end
			endcase
			r.left_drive = ld[DRIVE_W-1:0];
			r.right_drive = rd[DRIVE_W-1:0];
			r.left_tgt = left_tgt[TGT_W-1:0];
			r.right_tgt = right_tgt[TGT_W-1:0];
			drive_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINT)
				$display("MISMATCH %s", msg);
		endtask

		// Compare one accepted result transfer with the oldest expectation
		task check_result(logic [OUT_W-1:0] data, logic [0:0] flag);
			drive_result_t e;
			n_checked++;
			if (drive_q.size() == 0) begin
				report($sformatf("result %0d: none expected, tdata %h", n_checked, data));
				return;
			end
			e = drive_q.pop_front();
			if (data[0 +: DRIVE_W] !== e.left_drive)
				report($sformatf("result %0d: left_drive %0d, expected %0d", n_checked,
					$signed(data[0 +: DRIVE_W]), $signed(e.left_drive)));
			if (data[RD_LO +: DRIVE_W] !== e.right_drive)
				report($sformatf("result %0d: right_drive %0d, expected %0d", n_checked,
					$signed(data[RD_LO +: DRIVE_W]), $signed(e.right_drive)));
			if (flag[0] !== e.timed_out)
				report($sformatf("result %0d: timed_out %b, expected %b", n_checked,
					flag[0], e.timed_out));
			if (data[LT_LO +: TGT_W] !== e.left_tgt)
				report($sformatf("result %0d: left_target_now %0d, expected %0d", n_checked,
					$signed(data[LT_LO +: TGT_W]), $signed(e.left_tgt)));
			if (data[RT_LO +: TGT_W] !== e.right_tgt)
				report($sformatf("result %0d: right_target_now %0d, expected %0d", n_checked,
					$signed(data[RT_LO +: TGT_W]), $signed(e.right_tgt)));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;   // left_target_cmd, right_target_cmd, left_speed, right_speed
	logic [1:0]          s_axis_tuser;   // action
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;   // left_drive, right_drive, left_target_now, right_target_now
	logic [0:0]          m_axis_tuser;   // timed_out
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	wheel_scoreboard sb;
	int items_sent;
	bit tx_burst;
	bit rx_burst;
	logic rx_hold;

	dual_wheel_pid_with_command_timeout #(
		.SPEED_BITS(SPD_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] rand16();
		logic [31:0] w;
		w = $urandom();
		return w[15:0];
	endfunction

	// Mostly values around the target range, sometimes full-range or extreme words
	function automatic logic [15:0] draw_value(int margin);
		int span;
		int v;
		span = sb.cfg_tgt_limit + margin;
		case ($urandom_range(0, 7))
			0: return rand16();
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'h0000;
			default: begin
				v = int'($urandom_range(0, 2*span)) - span;
				return v[15:0];
			end
		endcase
	endfunction

	// Offer one input transfer after a random gap and hold it until accepted
	task automatic send_item(input action_t act, input logic [15:0] ltc, rtc, lsp, rsp);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {rsp, lsp, rtc, ltc};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(act, {rsp, lsp, rtc, ltc});
		items_sent++;
		if (items_sent % 48 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
		@(negedge clk);
	endtask

	// Mostly command episodes: a target, then ticks and control steps; the rest is noise
	task automatic random_items(int n);
		int sent;
		int steps;
		int ticks;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) != 0) begin
				send_item(ACT_SET_TARGET, draw_value(4), draw_value(4), rand16(), rand16());
				sent++;
				steps = $urandom_range(1, 8);
				repeat (steps) begin
					ticks = $urandom_range(0, 3);
					// walk the age right up to the timeout, or one past it
					if (ticks == 3 && sb.cfg_timeout < 16)
						ticks = sb.cfg_timeout + $urandom_range(0, 1);
					repeat (ticks) begin
						send_item(ACT_MS_TICK, rand16(), rand16(), rand16(), rand16());
						sent++;
					end
					send_item(ACT_CONTROL, rand16(), rand16(), draw_value(64), draw_value(64));
					sent++;
				end
			end else begin
				send_item(action_t'($urandom_range(0, 3)), rand16(), rand16(), rand16(),
					rand16());
				sent++;
			end
		end
	endtask

	// Drop valid, drain every expected result, then let any silent item finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.drive_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value when pready is seen
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [31:0] t, tl, pwm, ff, kp, kd, il);
		reg_write(REG_TIMEOUT, t);
		reg_write(REG_TGT_LIMIT, tl);
		reg_write(REG_DRIVE_LIMIT, pwm);
		reg_write(REG_FEED_FWD, ff);
		reg_write(REG_PROP_GAIN, kp);
		reg_write(REG_DERIV_GAIN, kd);
		reg_write(REG_INTEG_LIMIT, il);
	endtask

	// Register settings per phase: extremes first, then random, then back to defaults
	task automatic load_phase(int phase);
		case (phase)
			1: write_all(32'd3, 32'd1023, 32'd65535, 32'd0, 32'd255, 32'd255, 32'd32767);
			2: write_all(32'd1, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd0, 32'd0);
			3: write_all(32'd65534, 32'd1, 32'd7199, 32'd3600, 32'd18, 32'd4, 32'd8000);
			4: begin
				reg_write(UNMAPPED_REG, 32'h0000_0005);
				write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end
			8: write_all(32'(TIMEOUT_RST), 32'(TGT_LIMIT_RST), 32'(DRIVE_LIMIT_RST),
				32'(FEED_FWD_RST), 32'(PROP_GAIN_RST), 32'(DERIV_GAIN_RST),
				32'(INTEG_LIMIT_RST));
			default: write_all($urandom_range(1, 12), $urandom_range(0, 1023),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 32767));
		endcase
	endtask

	// Result side: random stalls per transfer, long holds on request, check each transfer
	initial begin : result_sink
		int stall;
		int n_results;
		stall = 0;
		n_results = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata, m_axis_tuser);
				n_results++;
				if (n_results % 40 == 0)
					rx_burst = ($urandom_range(0, 3) == 0);
				stall = rx_burst ? 0 : $urandom_range(0, 8);
			end
		end
	end

	// Hold the result side off for long stretches while items keep coming
	initial begin : backpressure
		rx_hold = 1'b0;
		for (int k = 0; k < 2; k++) begin
			wait (items_sent >= 300 + 800*k);
			@(negedge clk);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin : watchdog
		#5000000;
		$display("** dual_wheel_pid_with_command_timeout: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int phase;
		sb = new();
		items_sent = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_SET_TARGET;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stale command out of reset: control steps stop, the tick leaves the age unchanged
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_MS_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(ACT_CONTROL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// extreme commands clamp to the target limit; extreme speeds clamp the drive
		send_item(ACT_SET_TARGET, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'd150, 16'hFF6A);
		send_item(ACT_MS_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'd140, 16'hFF60);
		// emergency stop, then a control step with both targets zero
		send_item(ACT_ESTOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'd5, 16'd5);
		// one wheel parked on a zero target, the other running
		send_item(ACT_SET_TARGET, 16'h0000, 16'd7, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'd3, 16'd3);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'hFFFD, 16'd9);
		// smallest targets, negative integral truncation
		send_item(ACT_SET_TARGET, 16'hFFFF, 16'd1, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'd1, 16'hFFFF);
		send_item(ACT_MS_TICK, 16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5);
		send_item(ACT_CONTROL, 16'hA5A5, 16'h5A5A, 16'd20, 16'hFFEC);
		send_item(ACT_ESTOP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_CONTROL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		random_items(200);
		settle();
		for (phase = 1; phase <= 8; phase++) begin
			load_phase(phase);
			random_items(195);
			settle();
		end

		if (sb.errors == 0 && sb.drive_q.size() == 0)
			$display("** dual_wheel_pid_with_command_timeout: PASSED **");
		else
			$display("** dual_wheel_pid_with_command_timeout: FAILED **");
		$finish;
	end

endmodule
